/* design/sarq_pkg.sv */
package sarq_pkg;

    localparam int NUM_PROCS_DEF   = 32;
    localparam int NUM_SEMS_DEF    = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 5;
    localparam int INIT_W   = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC    = 3'd0,
        REQ_ACQUIRE  = 3'd1,
        REQ_RELEASE  = 3'd2,
        REQ_READY    = 3'd3,
        REQ_SCHEDULE = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_SWITCHED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOSEM    = 3'd3,
        ST_BADID    = 3'd4,
        ST_NOWAITER = 3'd5,
        ST_SAT      = 3'd6,
        ST_NORUN    = 3'd7
    } status_t;

endpackage

/* design/semaphore_and_ready_queue_unit.sv */
// A request is captured in the input register, worked on from there, and its result
// word is registered in the result register and marked by done for one cycle.
// busy is held while a request is in flight, so a new request word is not taken
// until the one before it has been worked on in the queue state.
// Reset (rst_n low, asynchronous) empties every queue, frees all semaphores and
// leaves nothing running; the receiver cannot stall results.
module semaphore_and_ready_queue_unit
    import sarq_pkg::*;
#(
    parameter int NUM_PROCS   = NUM_PROCS_DEF,
    parameter int NUM_SEMS    = NUM_SEMS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [ID_W-1:0]     pid,
    input  logic [ID_W-1:0]     sem_id,
    input  logic signed [INIT_W-1:0] init_value,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     pid_out,
    output logic                pid_valid,
    output logic [ID_W-1:0]     sem_id_out
);

    // Link and semaphore stores are sized to the full id range of the ports,
    // so every id field indexes them without extra range logic.
    localparam int IDS = 1 << ID_W;
    localparam int SA_W = $clog2(NUM_SEMS + 1);
    // The initial count is compared against the counter limits at a width
    // that holds both without loss.
    localparam int XW = ((COUNT_WIDTH > INIT_W) ? COUNT_WIDTH : INIT_W) + 1;

    // Input register: the request is captured here and worked on in the
    // following cycle.
    logic                     in_vld_reg;
    logic [REQ_W-1:0]         req_reg;
    logic [ID_W-1:0]          pid_reg;
    logic [ID_W-1:0]          sid_reg;
    logic signed [INIT_W-1:0] ival_reg;

    // Scheduler state.
    logic [ID_W-1:0]              next_link_reg [IDS];
    logic [IDS-1:0]               in_rq_reg, in_wq_reg;
    logic [ID_W-1:0]              rhead_reg, rtail_reg;
    logic                         rne_reg;
    logic [ID_W-1:0]              whead_reg [IDS];
    logic [ID_W-1:0]              wtail_reg [IDS];
    logic [IDS-1:0]               wne_reg;
    logic signed [COUNT_WIDTH-1:0] cnt_reg [IDS];
    logic [SA_W-1:0]              salloc_reg;
    logic [ID_W-1:0]              run_pid_reg;
    logic                         run_vld_reg;

    // Result register.
    logic                done_reg, pval_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     pout_reg, sout_reg;

    localparam logic signed [COUNT_WIDTH-1:0] CMAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CMIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // Decoded work for this request.
    logic [STATUS_W-1:0] st_c;
    logic [ID_W-1:0]     pout_c, sout_c;
    logic                pval_c;
    logic                do_alloc, do_cnt, do_wpush, do_wpop, do_rpush, do_rpop;
    logic                do_run, run_vld_c;
    logic signed [COUNT_WIDTH-1:0] cnt_c, clamp_c;
    logic [ID_W-1:0]     rpush_pid, wpop_pid, rpop_pid;
    logic                sid_ok, pid_ok;
    logic signed [COUNT_WIDTH-1:0] cur_cnt;
    logic signed [XW-1:0]          ival_x;

    assign sid_ok  = ({{(32-SA_W){1'b0}}, salloc_reg} > 32'(sid_reg))
                     && (32'(sid_reg) < NUM_SEMS);
    assign pid_ok  = 32'(pid_reg) < NUM_PROCS;
    assign cur_cnt = cnt_reg[sid_reg];
    assign ival_x  = XW'(ival_reg);
    assign wpop_pid = whead_reg[sid_reg];
    assign rpop_pid = rhead_reg;

    always_comb
    begin
        st_c = ST_OK; pout_c = '0; sout_c = '0; pval_c = 1'b0;
        do_alloc = 1'b0; do_cnt = 1'b0; do_wpush = 1'b0; do_wpop = 1'b0;
        do_rpush = 1'b0; do_rpop = 1'b0; do_run = 1'b0; run_vld_c = run_vld_reg;
        cnt_c = cur_cnt; rpush_pid = pid_reg;
        clamp_c = COUNT_WIDTH'(ival_reg);
        if ($signed(ival_x) > $signed(XW'(CMAX)))
        begin
            clamp_c = CMAX;
        end
        else if ($signed(ival_x) < $signed(XW'(CMIN)))
        begin
            clamp_c = CMIN;
        end
        unique case (req_reg)
            REQ_ALLOC:
            begin
                if (32'(salloc_reg) >= NUM_SEMS)
                begin
                    st_c = ST_NOSEM;
                end
                else
                begin
                    do_alloc = 1'b1;
                    sout_c = ID_W'(salloc_reg);
                    if (clamp_c != COUNT_WIDTH'(ival_reg) ||
                        $signed(ival_x) != $signed(XW'(clamp_c)))
                    begin
                        st_c = ST_SAT;
                    end
                end
            end
            REQ_ACQUIRE:
            begin
                if (!sid_ok) st_c = ST_BADID;
                else if (!run_vld_reg) st_c = ST_NORUN;
                else if (cur_cnt == CMIN) st_c = ST_SAT;
                else
                begin
                    do_cnt = 1'b1;
                    cnt_c = cur_cnt - 1'b1;
                    if (cnt_c < 0)
                    begin
                        do_wpush = 32'(run_pid_reg) < NUM_PROCS
                                   && !in_rq_reg[run_pid_reg] && !in_wq_reg[run_pid_reg];
                        if (rne_reg)
                        begin
                            do_rpop = 1'b1; do_run = 1'b1; run_vld_c = 1'b1;
                            st_c = ST_SWITCHED; pout_c = rpop_pid; pval_c = 1'b1;
                        end
                        else
                        begin
                            run_vld_c = 1'b0; st_c = ST_EMPTY;
                        end
                    end
                end
            end
            REQ_RELEASE:
            begin
                if (!sid_ok) st_c = ST_BADID;
                else if (cur_cnt == CMAX) st_c = ST_SAT;
                else
                begin
                    do_cnt = 1'b1;
                    cnt_c = cur_cnt + 1'b1;
                    if (cnt_c <= 0)
                    begin
                        if (wne_reg[sid_reg])
                        begin
                            do_wpop = 1'b1; do_rpush = 1'b1; rpush_pid = wpop_pid;
                            pout_c = wpop_pid; pval_c = 1'b1;
                        end
                        else st_c = ST_NOWAITER;
                    end
                end
            end
            REQ_READY:
            begin
                if (!pid_ok) st_c = ST_BADID;
                else if (!in_rq_reg[pid_reg] && !in_wq_reg[pid_reg]) do_rpush = 1'b1;
            end
            REQ_SCHEDULE:
            begin
                if (rne_reg)
                begin
                    do_rpop = 1'b1; do_run = 1'b1; run_vld_c = 1'b1;
                    pout_c = rpop_pid; pval_c = 1'b1;
                end
                else st_c = ST_EMPTY;
            end
            default: st_c = ST_BADID;
        endcase
    end

    assign busy = in_vld_reg;

    // Control and status state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            done_reg    <= 1'b0;
            in_rq_reg   <= '0;
            in_wq_reg   <= '0;
            wne_reg     <= '0;
            rne_reg     <= 1'b0;
            rhead_reg   <= '0;
            rtail_reg   <= '0;
            salloc_reg  <= '0;
            run_pid_reg <= '0;
            run_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            done_reg   <= in_vld_reg;
            if (in_vld_reg && in_vld_reg == 1'b1)
            begin
                if (do_alloc)
                begin
                    salloc_reg <= salloc_reg + 1'b1;
                    wne_reg[sout_c] <= 1'b0;
                end
                run_vld_reg <= run_vld_c;
                if (do_run) run_pid_reg <= rpop_pid;
                // Pop and push of the ready queue never coincide.
                if (do_rpop)
                begin
                    in_rq_reg[rpop_pid] <= 1'b0;
                    if (rhead_reg == rtail_reg) rne_reg <= 1'b0;
                    else rhead_reg <= next_link_reg[rhead_reg];
                end
                if (do_rpush)
                begin
                    if (!rne_reg) rhead_reg <= rpush_pid;
                    rtail_reg <= rpush_pid;
                    rne_reg <= 1'b1;
                    in_rq_reg[rpush_pid] <= 1'b1;
                end
                if (do_wpush)
                begin
                    wne_reg[sid_reg] <= 1'b1;
                    in_wq_reg[run_pid_reg] <= 1'b1;
                end
                if (do_wpop)
                begin
                    in_wq_reg[wpop_pid] <= 1'b0;
                    if (wpop_pid == wtail_reg[sid_reg]) wne_reg[sid_reg] <= 1'b0;
                end
            end
        end
    end

    // Stores without reset, and the input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= req_type; pid_reg <= pid; sid_reg <= sem_id; ival_reg <= init_value;
        end
        status_reg <= st_c; pout_reg <= pout_c; pval_reg <= pval_c; sout_reg <= sout_c;
        if (in_vld_reg)
        begin
            if (do_alloc) cnt_reg[sout_c] <= clamp_c;
            if (do_cnt) cnt_reg[sid_reg] <= cnt_c;
            if (do_rpush && rne_reg) next_link_reg[rtail_reg] <= rpush_pid;
            if (do_wpush)
            begin
                if (wne_reg[sid_reg]) next_link_reg[wtail_reg[sid_reg]] <= run_pid_reg;
                else whead_reg[sid_reg] <= run_pid_reg;
                wtail_reg[sid_reg] <= run_pid_reg;
            end
            if (do_wpop && wpop_pid != wtail_reg[sid_reg])
                whead_reg[sid_reg] <= next_link_reg[wpop_pid];
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign pid_out    = pout_reg;
    assign pid_valid  = pval_reg;
    assign sem_id_out = sout_reg;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> done_reg) else $error("result word missing");
    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg |=> !in_vld_reg) else $error("request overlap");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (in_rq_reg & in_wq_reg) == '0) else $error("pid in two queues");
    a_pval: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && pval_reg |-> (status_reg == ST_OK || status_reg == ST_SWITCHED))
        else $error("pid valid with error status");
`endif

endmodule
